// ===== sv/sitda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

   // Decimal digits needed for any magnitude up to 2**31.
   localparam int NumDigits    = 10;
   localparam int MagWidth     = 32;
   localparam int BcdWidth     = 4 * NumDigits;
   // Magnitude bits folded into the BCD register per conversion cycle.
   localparam int BitsPerStep  = 4;
   localparam int StepCount    = MagWidth / BitsPerStep;
   localparam int StepCntWidth = $clog2(StepCount);
   localparam int MaxText      = 11;

   localparam logic [5:0] CharMinus = 6'd45;
   localparam logic [5:0] CharZero  = 6'd48;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture a new request and form its magnitude
      logic step;     // fold the next group of magnitude bits into BCD
      logic measure;  // count the significant digits and set the text length
      logic advance;  // move to the next character of the text
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_char;  // the current character ends the text
   } sts_type;

endpackage

`default_nettype wire

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Sequence: after a request is accepted, its magnitude is converted to BCD, 4 bits
// per conversion step, and its text length is measured; the first character is then
// valid, and after that one character per cycle while the receiver does not stall.
// Requests: a new request is taken only when the block is idle, after the last
// character of the previous one has been handed over; a text has N = 1 to 11
// characters.
// Reset is synchronous and active high; it returns the controller to idle, while
// the datapath registers are simply reloaded by the next request.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_char_code,
   output logic             rsp_last,
   output logic [3:0]       rsp_text_length
);

   // The controller sequences each request through load, conversion, length
   // measurement and character output. The datapath holds the magnitude, the
   // BCD digits and the output position; all its result fields depend only on its
   // registers, so they hold steady while the result channel stalls.
   sitda_pkg::cmd_type cmd;
   sitda_pkg::sts_type sts;

   sitda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The magnitude of a negative value is formed as an unsigned 32-bit
   // quantity, which covers the most negative input without overflow.
   sitda_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_value       (req_value),
      .rsp_char_code   (rsp_char_code),
      .rsp_last        (rsp_last),
      .rsp_text_length (rsp_text_length)
   );

endmodule

`default_nettype wire

// ===== sv/sitda_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sitda_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sitda_pkg::cmd_type cmd,
   output sitda_pkg::sts_type     sts,
   input  wire logic [31:0]       req_value,
   output logic [5:0]             rsp_char_code,
   output logic                   rsp_last,
   output logic [3:0]             rsp_text_length
);

   logic                            neg_ff, neg_in;
   logic [sitda_pkg::MagWidth-1:0]  mag_ff, mag_in;
   logic [sitda_pkg::BcdWidth-1:0]  bcd_ff, bcd_in;
   logic [3:0]                      len_ff, len_in;
   logic [3:0]                      pos_ff, pos_in;

   logic [sitda_pkg::BcdWidth-1:0]  bcd_step;
   logic [sitda_pkg::MagWidth-1:0]  mag_step;
   logic [3:0]                      ndig;
   logic [3:0]                      digit_idx;
   logic [3:0]                      digit;

   // Double dabble: BitsPerStep shift-and-correct passes per cycle.
   always_comb begin
      bcd_step = bcd_ff;
      mag_step = mag_ff;
      for (int s = 0; s < sitda_pkg::BitsPerStep; s++) begin
         for (int d = 0; d < sitda_pkg::NumDigits; d++) begin
            if (bcd_step[d*4 +: 4] >= 4'd5) begin
               bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
            end
         end
         bcd_step = {bcd_step[sitda_pkg::BcdWidth-2:0], mag_step[sitda_pkg::MagWidth-1]};
         mag_step = {mag_step[sitda_pkg::MagWidth-2:0], 1'b0};
      end
   end

   // Number of significant digits; zero still gives one digit.
   always_comb begin
      ndig = 4'd1;
      for (int d = 1; d < sitda_pkg::NumDigits; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            ndig = 4'(d + 1);
         end
      end
   end

   always_comb begin
      neg_in = neg_ff;
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      len_in = len_ff;
      pos_in = pos_ff;
      if (cmd.load) begin
         neg_in = req_value[31];
         mag_in = req_value[31] ? (32'd0 - req_value) : req_value;
         bcd_in = '0;
      end else if (cmd.step) begin
         mag_in = mag_step;
         bcd_in = bcd_step;
      end else if (cmd.measure) begin
         len_in = ndig + {3'd0, neg_ff};
         pos_in = 4'd0;
      end else if (cmd.advance) begin
         pos_in = pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      len_ff <= len_in;
      pos_ff <= pos_in;
   end

   // Text position p shows digit (len - 1 - p), counted from the units digit, except for a leading minus sign.
   assign digit_idx = len_ff - 4'd1 - pos_ff;

   always_comb begin
      digit = 4'd0;
      if (digit_idx < 4'(sitda_pkg::NumDigits)) begin
         digit = bcd_ff[{digit_idx, 2'b00} +: 4];
      end
   end

   assign rsp_char_code   = (neg_ff && pos_ff == 4'd0) ? sitda_pkg::CharMinus
                                                       : sitda_pkg::CharZero + {2'b00, digit};
   assign rsp_last        = (pos_ff == len_ff - 4'd1);
   assign rsp_text_length = len_ff;
   assign sts.last_char   = rsp_last;

   // The text length is always within one to eleven characters.
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      cmd.measure |=> (len_ff != 4'd0 && len_ff <= 4'(sitda_pkg::MaxText)))
      else $error("text length out of range");

   // A negative value always has at least two characters.
   a_neg_len: assert property (@(posedge clock) disable iff (reset)
      cmd.measure |=> (!neg_ff || len_ff >= 4'd2))
      else $error("negative value without digits");

endmodule

`default_nettype wire

// ===== sv/sitda_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sitda_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sitda_pkg::cmd_type     cmd,
   input  wire sitda_pkg::sts_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_MEASURE = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   state_type                         state_ff, state_in;
   logic [sitda_pkg::StepCntWidth-1:0] step_ff, step_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == sitda_pkg::StepCntWidth'(sitda_pkg::StepCount - 1)) begin
               state_in = ST_MEASURE;
            end
         end
         ST_MEASURE: begin
            cmd.measure = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               cmd.advance = 1'b1;
               if (sts.last_char) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // An accepted request always starts a conversion.
   a_accept_converts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CONVERT && step_ff == '0))
      else $error("request accepted without starting conversion");

   // Handing over the final character frees the block for a new request.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && sts.last_char) |=> !req_stall)
      else $error("block not idle after final character");

   // A length measurement always directly follows a conversion step.
   a_full_convert: assert property (@(posedge clock) disable iff (reset)
      cmd.measure |-> $past(cmd.step))
      else $error("measure without conversion");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

// Testbench for signed_int_to_decimal_ascii.
//
// Every request carries one signed 32-bit value. The block answers with the
// value's decimal text, one character per result, most significant first.
// For each accepted request the bench formats the value itself and queues the
// characters it expects. A checker pops one expectation for every accepted
// result and compares the character code, the last flag and the text length.
//
// The run has three idling mixes. First the sender rarely idles while the
// receiver stalls most cycles. Then the roles swap. Last, neither side idles.
module tb;

   // One character of decimal text, as the block reports it.
   typedef struct packed {
      logic [5:0] char_code;
      logic       last;
      logic [3:0] text_length;
   } text_char_t;

   // The longest correct wait with no handshake on either side is a
   // conversion plus a run of receiver stalls or sender gaps. At 71 percent
   // idling such runs stay short, so QuietLimit quiet cycles can only mean
   // the block has hung.
   localparam int QuietLimit = 2000;

   // Cycles allowed after the last expected character, so that a stray
   // extra character would still be caught.
   localparam int TailCycles = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_char_code;
   logic        rsp_last;
   logic [3:0]  rsp_text_length;

   // Characters predicted but not yet returned, oldest first.
   text_char_t expected_chars[$];

   // Idling of each side, in percent of cycles.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   int          error_count = 0;
   int          values_sent = 0;
   int          negatives_sent = 0;
   int          chars_checked = 0;
   logic [11:0] lengths_seen = '0;

   signed_int_to_decimal_ascii dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_code   (rsp_char_code),
      .rsp_last        (rsp_last),
      .rsp_text_length (rsp_text_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Format one value as decimal text and queue its characters. The
   // magnitude is taken as an unsigned 32-bit quantity, which is what makes
   // the most negative value come out as "-2147483648".
   function automatic void format_decimal_text(input logic [31:0] value);
      logic        negative;
      logic [31:0] magnitude;
      logic [3:0]  digit_lsd_first [sitda_pkg::MaxText];
      int          ndigits;
      int          text_len;
      int          k;
      text_char_t  ch;

      negative  = value[31];
      magnitude = negative ? 32'd0 - value : value;
      ndigits   = 0;
      // Zero still yields one digit, so the loop body runs at least once.
      do begin
         digit_lsd_first[ndigits] = 4'(magnitude % 10);
         magnitude = magnitude / 10;
         ndigits++;
      end while (magnitude != 0);

      text_len = ndigits + (negative ? 1 : 0);
      lengths_seen[text_len] = 1'b1;

      if (negative) begin
         ch.char_code   = sitda_pkg::CharMinus;
         ch.last        = 1'b0;
         ch.text_length = 4'(text_len);
         expected_chars.push_back(ch);
      end
      for (k = ndigits - 1; k >= 0; k--) begin
         ch.char_code   = sitda_pkg::CharZero + {2'b00, digit_lsd_first[k]};
         ch.last        = (k == 0);
         ch.text_length = 4'(text_len);
         expected_chars.push_back(ch);
      end
   endfunction

   // Offer one request and return once it has been taken. The sender may
   // first idle for a random number of cycles. Valid is left high on return,
   // so back-to-back requests never drop it within one time step.
   task automatic send_value(input logic [31:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      format_decimal_text(value);
      values_sent++;
      if (value[31]) negatives_sent++;
   endtask

   // Hold off new requests until every predicted character has come back.
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   // A random value, shaped so that every text length shows up often: most
   // values have a randomly chosen digit count, some are raw 32-bit words
   // (which toggle every input bit), and a few are the awkward corners.
   function automatic logic [31:0] pick_random_value();
      int unsigned pick;
      int unsigned ndigits;
      int unsigned tenpow;
      int unsigned lo;
      int unsigned hi;
      logic [31:0] magnitude;

      pick = $urandom_range(99);
      if (pick < 30) return $urandom();
      if (pick < 40) begin
         case ($urandom_range(5))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            default: return 32'hFFFF_FFF6;
         endcase
      end
      ndigits = $urandom_range(10, 1);
      tenpow  = 1;
      repeat (ndigits - 1) tenpow = tenpow * 10;
      lo = (ndigits == 1) ? 0 : tenpow;
      hi = (ndigits == 10) ? 32'h7FFF_FFFF : tenpow * 10 - 1;
      magnitude = $urandom_range(hi, lo);
      return ($urandom_range(1) == 1) ? 32'd0 - magnitude : magnitude;
   endfunction

   // The receiver stalls at random according to the current mix.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Compare every accepted character with the oldest prediction.
   always @(posedge clock) begin
      text_char_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         chars_checked++;
         if (expected_chars.size() == 0) begin
            $error("character %0d arrived with no request outstanding", rsp_char_code);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_char_code !== want.char_code) begin
               $error("char_code: expected %0d, actual %0d", want.char_code, rsp_char_code);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               error_count++;
            end
            if (rsp_text_length !== want.text_length) begin
               $error("text_length: expected %0d, actual %0d",
                      want.text_length, rsp_text_length);
               error_count++;
            end
         end
      end
   end

   // Watchdog: give up once neither channel has moved for too long.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QuietLimit) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Timeout: no handshake in %0d cycles", QuietLimit);
      $display("FAILED: results differ");
      $finish;
   end

   // Zero, single-digit values, minus one and minus nine: the shortest texts.
   task automatic test_short_texts();
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'd9);
      send_value(32'hFFFF_FFFF);
      send_value(32'hFFFF_FFF7);
   endtask

   // The ends of the 32-bit range, including the most negative value, whose
   // magnitude does not fit in a positive signed word.
   task automatic test_range_extremes();
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'h8000_0001);
      send_value(32'h7FFF_FFFE);
   endtask

   // Values on either side of a change in digit count, and texts that use
   // every digit.
   task automatic test_digit_count_edges();
      send_value(32'd10);
      send_value(-32'sd10);
      send_value(32'd99);
      send_value(-32'sd100);
      send_value(32'd999_999_999);
      send_value(32'd1_000_000_000);
      send_value(-32'sd999_999_999);
      send_value(-32'sd1_000_000_000);
      send_value(32'd1_234_567_890);
      send_value(-32'sd1_234_567_890);
      send_value(32'd987_654_321);
      send_value(32'd1_000_000_001);
   endtask

   task automatic test_random_values(input int count);
      repeat (count) send_value(pick_random_value());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Slow receiver: results pile up behind the stall.
      send_idle_pct = 8;
      recv_idle_pct = 71;
      test_short_texts();
      test_range_extremes();
      test_digit_count_edges();
      test_random_values(100);
      wait_until_drained();

      // Slow sender: the block often sits idle between requests.
      send_idle_pct = 71;
      recv_idle_pct = 8;
      test_random_values(100);
      wait_until_drained();

      // Full speed on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_values(100);

      wait_until_drained();
      repeat (TailCycles) @(posedge clock);
      if (expected_chars.size() != 0) begin
         $error("%0d predicted characters never arrived", expected_chars.size());
         error_count++;
      end

      $display("Converted %0d values (%0d negative), checked %0d characters.",
               values_sent, negatives_sent, chars_checked);
      $display("Text lengths seen (bit n for length n): %b", lengths_seen[11:1]);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
